@@ sv/scsi_initiator_command_sequencer_core_defines.svh @@
`ifndef SCSI_INITIATOR_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define SCSI_INITIATOR_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SCSI_SEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SCSI_SEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/scsi_seq_pkg.sv @@
package scsi_seq_pkg;

  localparam int CdbBytes    = 6;
  localparam int StatusBytes = 3;
  localparam int StatPack    = (StatusBytes < 3) ? StatusBytes : 3;
  localparam int StatCntBits = $clog2(StatusBytes + 1);

  localparam logic [23:0] ResetBusyLimit = 24'd100000;
  localparam logic [23:0] ResetIntLimit  = 24'd10000000;
  localparam logic [19:0] AddrMask       = 20'hFFFFF;

  localparam logic [1:0] CfgBusyLimit = 2'd0;
  localparam logic [1:0] CfgIntLimit  = 2'd1;
  localparam logic [1:0] CfgCompMsg   = 2'd2;

  localparam logic ActStart = 1'b0;

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhFree = 3'd1;
  localparam logic [2:0] PhSel  = 3'd2;
  localparam logic [2:0] PhCmd  = 3'd3;
  localparam logic [2:0] PhInt  = 3'd4;
  localparam logic [2:0] PhStat = 3'd5;
  localparam logic [2:0] PhMsg  = 3'd6;

  localparam int FlagBusy = 0;
  localparam int FlagReq  = 1;
  localparam int FlagInt  = 2;
  localparam int FlagBerr = 3;

  localparam logic [1:0] BpCommand = 2'd0;
  localparam logic [1:0] BpStatus  = 2'd1;
  localparam logic [1:0] BpMsgIn   = 2'd2;

  localparam logic [2:0] WkNone   = 3'd0;
  localparam logic [2:0] WkTarget = 3'd1;
  localparam logic [2:0] WkSelect = 3'd2;
  localparam logic [2:0] WkDma    = 3'd3;
  localparam logic [2:0] WkByte   = 3'd4;
  localparam logic [2:0] WkReset  = 3'd5;

  localparam logic [2:0] ErrOk      = 3'd0;
  localparam logic [2:0] ErrBusBusy = 3'd1;
  localparam logic [2:0] ErrNoSel   = 3'd2;
  localparam logic [2:0] ErrTimeout = 3'd3;
  localparam logic [2:0] ErrBusErr  = 3'd4;
  localparam logic [2:0] ErrSeq     = 3'd5;
  localparam logic [2:0] ErrBadMsg  = 3'd6;

  typedef struct packed {
    logic [23:0] busy_limit;
    logic [23:0] int_limit;
    logic [7:0]  comp_msg;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  target_select;
    logic [47:0] command_block;
    logic [15:0] transfer_length;
    logic [31:0] buffer_address;
    logic [3:0]  bus_flags;
    logic [1:0]  bus_phase;
    logic [7:0]  in_byte;
    logic [15:0] count_readback;
  } req_t;

  typedef struct packed {
    logic [2:0]  write_kind;
    logic [19:0] write_value;
    logic [15:0] count_value;
    logic        done_res;
    logic [2:0]  error_code;
    logic [15:0] transferred;
    logic [23:0] status_bytes;
  } res_t;

endpackage

@@ sv/scsi_seq_cfg.sv @@
module scsi_seq_cfg
  import scsi_seq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CfgBusyLimit: cfg_nxt.busy_limit = cfg_data;
        CfgIntLimit:  cfg_nxt.int_limit  = cfg_data;
        CfgCompMsg:   cfg_nxt.comp_msg   = cfg_data[7:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.busy_limit <= ResetBusyLimit;
      cfg_r.int_limit  <= ResetIntLimit;
      cfg_r.comp_msg   <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/scsi_seq_step.sv @@
module scsi_seq_step
  import scsi_seq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  req_t req,
  input  cfg_t cfg,
  output res_t res
);

  logic [2:0]             phase_r, phase_nxt;
  logic [23:0]            poll_count_r, poll_count_nxt;
  logic [2:0]             byte_index_r, byte_index_nxt;
  logic [47:0]            command_r, command_nxt;
  logic [15:0]            length_r, length_nxt;
  logic [19:0]            address_r, address_nxt;
  logic [StatCntBits-1:0] stat_cnt_r, stat_cnt_nxt;
  logic [7:0]             store_r   [StatusBytes];
  logic [7:0]             store_nxt [StatusBytes];

  logic [23:0] poll_inc;
  logic [23:0] wait_limit;
  logic        wait_met;
  logic        wait_tmo;
  logic        wait_berr;
  logic        fin;
  logic [2:0]  fin_err;
  logic [2:0]  msg_err;
  logic [2:0]  byte_index_inc;
  logic [7:0]  cmd_byte;
  logic [23:0] stat_pack;

  assign poll_inc       = poll_count_r + 24'd1;
  assign wait_limit     = (phase_r == PhInt) ? cfg.int_limit : cfg.busy_limit;
  assign wait_tmo       = (poll_inc >= wait_limit);
  assign wait_berr      = req.bus_flags[FlagBerr];
  assign byte_index_inc = byte_index_r + 3'd1;
  assign cmd_byte       = 8'(command_r >> {byte_index_r, 3'b000});

  always_comb begin
    unique case (phase_r)
      PhSel:   wait_met = req.bus_flags[FlagBusy];
      PhInt:   wait_met = req.bus_flags[FlagInt];
      default: wait_met = req.bus_flags[FlagReq];
    endcase
  end

  always_comb begin
    priority if (req.bus_phase != BpMsgIn) begin
      msg_err = ErrSeq;
    end else if (req.in_byte != cfg.comp_msg) begin
      msg_err = ErrBadMsg;
    end else begin
      msg_err = ErrOk;
    end
  end

  always_comb begin
    stat_pack = '0;
    for (int i = 0; i < StatPack; i++) begin
      stat_pack[8*i +: 8] = store_r[i];
    end
  end

  always_comb begin
    res            = '0;
    phase_nxt      = phase_r;
    poll_count_nxt = poll_count_r;
    byte_index_nxt = byte_index_r;
    command_nxt    = command_r;
    length_nxt     = length_r;
    address_nxt    = address_r;
    stat_cnt_nxt   = stat_cnt_r;
    store_nxt      = store_r;
    fin            = 1'b0;
    fin_err        = ErrOk;

    if (req.action == ActStart) begin
      command_nxt    = req.command_block;
      length_nxt     = req.transfer_length;
      address_nxt    = req.buffer_address[19:0] & AddrMask;
      for (int i = 0; i < StatusBytes; i++) begin
        store_nxt[i] = 8'd0;
      end
      stat_cnt_nxt   = '0;
      byte_index_nxt = 3'd0;
      poll_count_nxt = 24'd0;
      phase_nxt      = PhFree;
      res.write_kind  = WkTarget;
      res.write_value = {12'd0, req.target_select};
    end else begin
      if (phase_r != PhIdle && phase_r != PhFree && !wait_met) begin
        poll_count_nxt = poll_inc;
      end
      unique case (phase_r)
        PhIdle: begin
        end
        PhFree: begin
          priority if (!req.bus_flags[FlagBusy]) begin
            res.write_kind = WkSelect;
            poll_count_nxt = 24'd0;
            phase_nxt      = PhSel;
          end else if (poll_count_r >= cfg.busy_limit) begin
            res.write_kind = WkReset;
            fin            = 1'b1;
            fin_err        = ErrBusBusy;
          end else begin
            poll_count_nxt = poll_inc;
          end
        end
        PhSel: begin
          if (wait_met) begin
            res.write_kind  = WkDma;
            res.write_value = address_r;
            res.count_value = ~length_r;
            poll_count_nxt  = 24'd0;
            byte_index_nxt  = 3'd0;
            phase_nxt       = PhCmd;
          end else if (wait_tmo || wait_berr) begin
            fin     = 1'b1;
            fin_err = ErrNoSel;
          end
        end
        PhCmd: begin
          if (wait_met) begin
            if (req.bus_phase != BpCommand || byte_index_r >= 3'(CdbBytes)) begin
              fin     = 1'b1;
              fin_err = ErrSeq;
            end else begin
              res.write_kind  = WkByte;
              res.write_value = {12'd0, cmd_byte};
              byte_index_nxt  = byte_index_inc;
              poll_count_nxt  = 24'd0;
              if (byte_index_inc >= 3'(CdbBytes)) begin
                phase_nxt = PhInt;
              end
            end
          end else if (wait_tmo || wait_berr) begin
            fin     = 1'b1;
            fin_err = wait_tmo ? ErrTimeout : ErrBusErr;
          end
        end
        PhInt: begin
          if (wait_met) begin
            poll_count_nxt = 24'd0;
            phase_nxt      = PhStat;
          end else if (wait_tmo || wait_berr) begin
            fin     = 1'b1;
            fin_err = wait_tmo ? ErrTimeout : ErrBusErr;
          end
        end
        PhStat: begin
          if (wait_met) begin
            poll_count_nxt = 24'd0;
            if (req.bus_phase == BpStatus) begin
              for (int i = 0; i < StatusBytes; i++) begin
                if (stat_cnt_r == StatCntBits'(i)) begin
                  store_nxt[i] = req.in_byte;
                end
              end
              if (stat_cnt_r < StatCntBits'(StatusBytes)) begin
                stat_cnt_nxt = stat_cnt_r + StatCntBits'(1);
              end
            end else begin
              fin     = 1'b1;
              fin_err = msg_err;
            end
          end else if (wait_tmo || wait_berr) begin
            poll_count_nxt = 24'd0;
            phase_nxt      = PhMsg;
          end
        end
        PhMsg: begin
          if (wait_met) begin
            fin     = 1'b1;
            fin_err = msg_err;
          end else if (wait_tmo || wait_berr) begin
            fin     = 1'b1;
            fin_err = wait_tmo ? ErrTimeout : ErrBusErr;
          end
        end
        default: begin
          phase_nxt = PhIdle;
        end
      endcase
    end

    if (fin) begin
      res.done_res     = 1'b1;
      res.error_code   = fin_err;
      res.status_bytes = stat_pack;
      if (fin_err == ErrOk) begin
        res.transferred = length_r - ~req.count_readback;
      end
      phase_nxt = PhIdle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PhIdle;
      poll_count_r <= 24'd0;
      byte_index_r <= 3'd0;
      command_r    <= 48'd0;
      length_r     <= 16'd0;
      address_r    <= 20'd0;
      stat_cnt_r   <= '0;
      for (int i = 0; i < StatusBytes; i++) begin
        store_r[i] <= 8'd0;
      end
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      poll_count_r <= poll_count_nxt;
      byte_index_r <= byte_index_nxt;
      command_r    <= command_nxt;
      length_r     <= length_nxt;
      address_r    <= address_nxt;
      stat_cnt_r   <= stat_cnt_nxt;
      store_r      <= store_nxt;
    end
  end

endmodule

@@ sv/scsi_initiator_command_sequencer_core.sv @@
// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_ready   | in_action .. in_count_readback
// out      | output    | out_valid / out_ready | out_write_kind .. out_status_bytes
// cfg      | input     | cfg_we                | cfg_index, cfg_data
//
// Each request gives exactly one result, held in the result register.
// Throughput is one request per cycle while out_ready is high: an input register
// feeds the sequencer step logic, which writes the result register.
// Reset is synchronous, active low; it loads the default limits and idles.
// A stalled result holds the result register; the input register still
// takes a request while it is empty.
module scsi_initiator_command_sequencer_core
  import scsi_seq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_target_select,
  input  logic [47:0] in_command_block,
  input  logic [15:0] in_transfer_length,
  input  logic [31:0] in_buffer_address,
  input  logic [3:0]  in_bus_flags,
  input  logic [1:0]  in_bus_phase,
  input  logic [7:0]  in_in_byte,
  input  logic [15:0] in_count_readback,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_write_kind,
  output logic [19:0] out_write_value,
  output logic [15:0] out_count_value,
  output logic        out_done_res,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_transferred,
  output logic [23:0] out_status_bytes
);

`include "scsi_initiator_command_sequencer_core_defines.svh"

  cfg_t cfg;
  req_t req_r;
  req_t req_in;
  res_t res;
  res_t res_r;
  logic in_valid_r;
  logic out_valid_r;
  logic advance;

  assign req_in.action          = in_action;
  assign req_in.target_select   = in_target_select;
  assign req_in.command_block   = in_command_block;
  assign req_in.transfer_length = in_transfer_length;
  assign req_in.buffer_address  = in_buffer_address;
  assign req_in.bus_flags       = in_bus_flags;
  assign req_in.bus_phase       = in_bus_phase;
  assign req_in.in_byte         = in_in_byte;
  assign req_in.count_readback  = in_count_readback;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  scsi_seq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scsi_seq_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .req     (req_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_kind   = res_r.write_kind;
  assign out_write_value  = res_r.write_value;
  assign out_count_value  = res_r.count_value;
  assign out_done_res     = res_r.done_res;
  assign out_error_code   = res_r.error_code;
  assign out_transferred  = res_r.transferred;
  assign out_status_bytes = res_r.status_bytes;

  `SCSI_SEQ_ASSERT_NXT(a_step_loads_out, advance, out_valid_r, "step did not load result")
  `SCSI_SEQ_ASSERT_IMP(a_err_needs_done, out_valid_r && out_error_code != ErrOk,
                       out_done_res, "error code without done")
  `SCSI_SEQ_ASSERT_IMP(a_xfer_on_ok, out_valid_r && out_transferred != 16'd0,
                       out_done_res && out_error_code == ErrOk, "transferred without success")
  `SCSI_SEQ_ASSERT_IMP(a_reset_pulse_busy, out_valid_r && out_write_kind == WkReset,
                       out_done_res && out_error_code == ErrBusBusy, "reset pulse without busy fail")

endmodule
